@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define MCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/mce_pkg.sv @@
// Types and constants of the Morse code encoder.
// No dependencies; used by mce_lookup, morse_code_encoder and mce_checker.
package mce_pkg;

    // Symbol codes carried on the output.
    typedef enum logic [1:0] {
        SYM_DOT  = 2'd0,
        SYM_DASH = 2'd1,
        SYM_GAP  = 2'd2
    } t_symbol;

    // Longest run of symbols for one character.
    localparam int unsigned RUN_MAX = 9;
    localparam int unsigned MARK_MAX = 6;

    localparam logic [3:0] LETTER_GAPS = 4'd3;
    localparam logic [3:0] SPACE_GAPS  = 4'd4;

    localparam logic [7:0] LOWER_FIRST = 8'd97;
    localparam logic [7:0] LOWER_LAST  = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam logic [7:0] SPACE_CODE  = 8'd32;

    // Marks of one character: count, and pattern left-justified with the
    // first mark in the top bit (1 is a dash, 0 a dot).
    typedef struct packed {
        logic [2:0] len;
        logic [5:0] bits;
    } t_marks;

    // Whole run of one character: symbol slot k sits at seq[2k+1:2k].
    typedef struct packed {
        logic [3:0]           count;
        logic [2*RUN_MAX-1:0] seq;
    } t_run;

endpackage

@@ hdl/mce_lookup.sv @@
// Character to symbol-run decoder of the Morse code encoder.
// Depends on mce_pkg.
module mce_lookup (
    input  logic [7:0]    i_char_code,
    output mce_pkg::t_run o_run
);

    logic [7:0]      folded;
    mce_pkg::t_marks marks;
    logic            known;
    logic            is_space;
    logic [5:0]      shifted;

    // Fold lowercase letters to uppercase.
    always_comb begin
        if (i_char_code >= mce_pkg::LOWER_FIRST && i_char_code <= mce_pkg::LOWER_LAST) begin
            folded = i_char_code - mce_pkg::CASE_OFFSET;
        end else begin
            folded = i_char_code;
        end
    end

    // Morse table, patterns written in sending order.
    always_comb begin
        known = 1'b1;
        unique case (folded)
            "A": marks = '{3'd2, 6'b010000};
            "B": marks = '{3'd4, 6'b100000};
            "C": marks = '{3'd4, 6'b101000};
            "D": marks = '{3'd3, 6'b100000};
            "E": marks = '{3'd1, 6'b000000};
            "F": marks = '{3'd4, 6'b001000};
            "G": marks = '{3'd3, 6'b110000};
            "H": marks = '{3'd4, 6'b000000};
            "I": marks = '{3'd2, 6'b000000};
            "J": marks = '{3'd4, 6'b011100};
            "K": marks = '{3'd3, 6'b101000};
            "L": marks = '{3'd4, 6'b010000};
            "M": marks = '{3'd2, 6'b110000};
            "N": marks = '{3'd2, 6'b100000};
            "O": marks = '{3'd3, 6'b111000};
            "P": marks = '{3'd4, 6'b011000};
            "Q": marks = '{3'd4, 6'b110100};
            "R": marks = '{3'd3, 6'b010000};
            "S": marks = '{3'd3, 6'b000000};
            "T": marks = '{3'd1, 6'b100000};
            "U": marks = '{3'd3, 6'b001000};
            "V": marks = '{3'd4, 6'b000100};
            "W": marks = '{3'd3, 6'b011000};
            "X": marks = '{3'd4, 6'b100100};
            "Y": marks = '{3'd4, 6'b101100};
            "Z": marks = '{3'd4, 6'b110000};
            "0": marks = '{3'd5, 6'b111110};
            "1": marks = '{3'd5, 6'b011110};
            "2": marks = '{3'd5, 6'b001110};
            "3": marks = '{3'd5, 6'b000110};
            "4": marks = '{3'd5, 6'b000010};
            "5": marks = '{3'd5, 6'b000000};
            "6": marks = '{3'd5, 6'b100000};
            "7": marks = '{3'd5, 6'b110000};
            "8": marks = '{3'd5, 6'b111000};
            "9": marks = '{3'd5, 6'b111100};
            "@": marks = '{3'd6, 6'b011010};
            "&": marks = '{3'd5, 6'b010000};
            "!": marks = '{3'd6, 6'b101011};
            "?": marks = '{3'd6, 6'b001100};
            ",": marks = '{3'd6, 6'b110011};
            ".": marks = '{3'd6, 6'b010101};
            default: begin
                marks = '{3'd0, 6'b000000};
                known = 1'b0;
            end
        endcase
    end

    // Lay out the marks followed by gaps; a space is gaps only.
    always_comb begin
        is_space = (folded == mce_pkg::SPACE_CODE);
        shifted  = '0;
        o_run.seq = '0;
        for (int pos = 0; pos < mce_pkg::RUN_MAX; pos++) begin
            shifted = marks.bits << pos;
            if (!is_space && (4'(pos) < {1'b0, marks.len})) begin
                o_run.seq[2*pos +: 2] = shifted[mce_pkg::MARK_MAX-1] ? mce_pkg::SYM_DASH
                                                                     : mce_pkg::SYM_DOT;
            end else begin
                o_run.seq[2*pos +: 2] = mce_pkg::SYM_GAP;
            end
        end
        if (is_space) begin
            o_run.count = mce_pkg::SPACE_GAPS;
        end else if (known) begin
            o_run.count = {1'b0, marks.len} + mce_pkg::LETTER_GAPS;
        end else begin
            o_run.count = 4'd0;
        end
    end

endmodule

@@ hdl/morse_code_encoder.sv @@
// Morse code encoder: one character word in, a run of dot/dash/gap words out.
// The accepted character is registered, decoded and loaded into the run register
// once that is free, and its first symbol is then offered on the output.
// Throughput: one symbol per cycle while i_out_ready is high; a character holds the output
// for its run length of 4 to 9 symbols, and an unknown character loads an empty run.
// The next character is decoded while the current run is still being sent.
// Reset (synchronous, active low) empties both stages; no memory to clear.
module morse_code_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_symbol,
    output logic       o_last_of_run
);

    logic          r_in_valid;
    logic [7:0]    r_char_code;
    mce_pkg::t_run r_run;
    mce_pkg::t_run n_run;
    mce_pkg::t_run lookup_run;
    logic          run_load;
    logic          run_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_char_code <= i_char_code;
        end
    end

    mce_lookup u_lookup (
        .i_char_code (r_char_code),
        .o_run       (lookup_run)
    );

    // The run register is free when empty or when its last symbol leaves now.
    assign run_free   = (r_run.count == 4'd0) || ((r_run.count == 4'd1) && i_out_ready);
    assign run_load   = r_in_valid && run_free;
    assign o_in_ready = !r_in_valid || run_free;

    // Run register: load a decoded run or shift out one symbol.
    always_comb begin
        n_run = r_run;
        if (run_load) begin
            n_run = lookup_run;
        end else if (o_out_valid && i_out_ready) begin
            n_run.count = r_run.count - 4'd1;
            n_run.seq   = {2'b00, r_run.seq[2*mce_pkg::RUN_MAX-1:2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run.count <= 4'd0;
        end else begin
            r_run.count <= n_run.count;
        end
        r_run.seq <= n_run.seq;
    end

    assign o_out_valid   = (r_run.count != 4'd0);
    assign o_symbol      = r_run.seq[1:0];
    assign o_last_of_run = (r_run.count == 4'd1);

endmodule

@@ hdl/mce_checker.sv @@
// Port-level checks of the Morse code encoder, bound to its top level.
// Depends on mce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mce_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_symbol,
    input logic       o_last_of_run
);

    logic       out_take;
    logic       out_stall;
    logic [2:0] out_word;
    logic       is_gap;

    assign out_take  = o_out_valid && i_out_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_word  = {o_symbol, o_last_of_run};
    assign is_gap    = (o_symbol == mce_pkg::SYM_GAP);

    // A stalled output word holds.
    `MCE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_word))

    // Every run closes with a gap, and symbol code three never shows.
    `MCE_ASSERT_IMPL(a_last_is_gap, i_clk, i_rst_n, o_out_valid && o_last_of_run, is_gap)
    `MCE_ASSERT_IMPL(a_symbol_legal, i_clk, i_rst_n, o_out_valid, o_symbol != 2'd3)

    // A run goes on without a bubble until its last word.
    `MCE_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, out_take && !o_last_of_run, o_out_valid)

    // Once the gaps start, only gaps follow within the run.
    `MCE_ASSERT_NEXT(a_gaps_trail, i_clk, i_rst_n, out_take && !o_last_of_run && is_gap, is_gap)

endmodule

bind morse_code_encoder mce_checker u_checker (.*);
